// ===== rtl/core/bld_pkg.sv =====
// Shared constants, codes and types for the bounded list deque.
`timescale 1ns / 1ps

package bld_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int IDX_W  = 6;
  localparam int ST_W   = 2;
  localparam int IN_W   = 48;
  localparam int RES_W  = DATA_W + ST_W + CNT_W;
  localparam int OUT_W  = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_AT    = 3'd4,
    OP_REMOVE_AT  = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SHIFT,
    S_DONE
  } state_e;

  // data sits in the low bits, count in the high bits
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    status_e           status;
    logic [DATA_W-1:0] data;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/bounded_list_deque.sv =====
// Top level of the bounded list deque: stream ports, output register, store and sequencer.
`timescale 1ns / 1ps

// Ordered list of up to 64 32-bit words kept in a circular buffer.
// Slave stream carries one request word: push back, push front, pop front,
// pop back, read at index, remove at index. Master stream returns exactly
// one result word per request: data, status (ok, empty, out of range, full)
// and the count held after the request.
// Requests run one at a time; s_axis_tready is high only while the
// sequencer is idle. A push or a failed request is done in S_EXEC, a pop
// or read waits in S_RD_WAIT for the registered read data, and remove at
// index then moves each entry after the index one slot toward the front,
// one entry moved per cycle through the single store write port.
// The result sits in an output register, so the next request is taken
// while it waits; a stalled receiver only holds a finished request in the
// sequencer. Reset empties the list (front and count cleared); the store
// itself is not cleared, as only written entries are ever read.

module bounded_list_deque (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [2:0] operation, [34:3] value, [40:35] index, [47:41] zero
  input  logic [bld_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [31:0] data, [33:32] status, [40:34] count, [47:41] zero
  output logic [bld_pkg::OUT_W-1:0]   m_axis_tdata
);

  bld_pkg::mem_req_t              mem_req;
  logic [bld_pkg::DATA_W-1:0]     mem_rdata;
  bld_pkg::result_t               res;
  logic                           res_valid;
  logic                           res_ready;

  logic                           out_valid_q, out_valid_d;
  bld_pkg::result_t               out_res_q;

  bld_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bld_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tdata[bld_pkg::OP_W-1:0]),
    .in_value_i  (s_axis_tdata[bld_pkg::OP_W +: bld_pkg::DATA_W]),
    .in_index_i  (s_axis_tdata[bld_pkg::OP_W + bld_pkg::DATA_W +: bld_pkg::IDX_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bld_pkg::OUT_W - bld_pkg::RES_W){1'b0}}, out_res_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_res_q.count <= bld_pkg::CNT_W'(bld_pkg::DEPTH)))
    else $error("result count above depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.status == bld_pkg::ST_FULL)
      |-> (out_res_q.count == bld_pkg::CNT_W'(bld_pkg::DEPTH)))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.status == bld_pkg::ST_EMPTY)
      |-> (out_res_q.count == '0 && out_res_q.data == '0))
    else $error("empty status with entries held or nonzero data");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while sequencer busy");
`endif

endmodule

// ===== rtl/core/bld_ram.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bld_ram (
  input  logic                         clk_i,
  input  bld_pkg::mem_req_t            req_i,
  output logic [bld_pkg::DATA_W-1:0]   rdata_o
);

  logic [bld_pkg::DATA_W-1:0] mem_q [bld_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

// ===== rtl/core/bld_seq.sv =====
// Request sequencer: runs each operation over the entry store through one slot adder.
`timescale 1ns / 1ps

module bld_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bld_pkg::OP_W-1:0]     in_op_i,
  input  logic [bld_pkg::DATA_W-1:0]   in_value_i,
  input  logic [bld_pkg::IDX_W-1:0]    in_index_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output bld_pkg::result_t             res_o,
  output bld_pkg::mem_req_t            mem_req_o,
  input  logic [bld_pkg::DATA_W-1:0]   mem_rdata_i
);

  bld_pkg::state_e                state_q, state_d;
  logic [bld_pkg::ADDR_W-1:0]     front_q, front_d;
  logic [bld_pkg::CNT_W-1:0]      held_q, held_d;

  logic [bld_pkg::OP_W-1:0]       op_q, op_d;
  logic [bld_pkg::DATA_W-1:0]     val_q, val_d;
  logic [bld_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [bld_pkg::CNT_W-1:0]      j_q, j_d;
  logic [bld_pkg::ADDR_W-1:0]     rd_slot_q, rd_slot_d;
  logic [bld_pkg::ADDR_W-1:0]     wr_slot_q, wr_slot_d;
  logic [bld_pkg::DATA_W-1:0]     data_q, data_d;
  bld_pkg::status_e               status_q, status_d;

  // shared slot adder: slot = front + position, wraps at DEPTH
  logic [bld_pkg::ADDR_W-1:0]     pos;
  logic [bld_pkg::ADDR_W-1:0]     slot;
  logic                           is_full;
  logic                           is_empty;

  assign slot     = front_q + pos;
  assign is_full  = (held_q == bld_pkg::CNT_W'(bld_pkg::DEPTH));
  assign is_empty = (held_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bld_pkg::S_IDLE;
      front_q <= '0;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    j_q       <= j_d;
    rd_slot_q <= rd_slot_d;
    wr_slot_q <= wr_slot_d;
    data_q    <= data_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    held_d    = held_q;
    op_d      = op_q;
    val_d     = val_q;
    idx_d     = idx_q;
    j_d       = j_q;
    rd_slot_d = rd_slot_q;
    wr_slot_d = wr_slot_q;
    data_d    = data_q;
    status_d  = status_q;
    pos       = '0;
    mem_req_o = '0;

    case (state_q)
      bld_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op_i;
          val_d   = in_value_i;
          idx_d   = in_index_i;
          state_d = bld_pkg::S_EXEC;
        end
      end

      bld_pkg::S_EXEC: begin
        data_d   = '0;
        status_d = bld_pkg::ST_OK;
        state_d  = bld_pkg::S_DONE;
        case (op_q)
          bld_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
              status_d = bld_pkg::ST_FULL;
            end else begin
              pos             = held_q[bld_pkg::ADDR_W-1:0];
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = slot;
              mem_req_o.wdata = val_q;
              held_d          = held_q + 1'b1;
            end
          end
          bld_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
              status_d = bld_pkg::ST_FULL;
            end else begin
              pos             = '1;  // front - 1 modulo DEPTH
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = slot;
              mem_req_o.wdata = val_q;
              front_d         = slot;
              held_d          = held_q + 1'b1;
            end
          end
          bld_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
              status_d = bld_pkg::ST_EMPTY;
            end else begin
              pos             = '0;
              mem_req_o.raddr = slot;
              state_d         = bld_pkg::S_RD_WAIT;
            end
          end
          bld_pkg::OP_POP_BACK: begin
            if (is_empty) begin
              status_d = bld_pkg::ST_EMPTY;
            end else begin
              pos             = bld_pkg::ADDR_W'(held_q - 1'b1);
              mem_req_o.raddr = slot;
              state_d         = bld_pkg::S_RD_WAIT;
            end
          end
          bld_pkg::OP_READ_AT, bld_pkg::OP_REMOVE_AT: begin
            if (is_empty) begin
              status_d = bld_pkg::ST_EMPTY;
            end else if ({1'b0, idx_q} >= held_q) begin
              status_d = bld_pkg::ST_RANGE;
            end else begin
              pos             = idx_q;
              mem_req_o.raddr = slot;
              rd_slot_d       = slot;
              j_d             = {1'b0, idx_q} + 1'b1;
              state_d         = bld_pkg::S_RD_WAIT;
            end
          end
          default: ;  // unused codes: no change, ok status
        endcase
      end

      bld_pkg::S_RD_WAIT: begin
        data_d  = mem_rdata_i;
        state_d = bld_pkg::S_DONE;
        case (op_q)
          bld_pkg::OP_POP_FRONT: begin
            pos     = bld_pkg::ADDR_W'(1);
            front_d = slot;
            held_d  = held_q - 1'b1;
          end
          bld_pkg::OP_POP_BACK: begin
            held_d = held_q - 1'b1;
          end
          bld_pkg::OP_REMOVE_AT: begin
            if (j_q < held_q) begin
              pos             = j_q[bld_pkg::ADDR_W-1:0];
              mem_req_o.raddr = slot;
              wr_slot_d       = rd_slot_q;
              rd_slot_d       = slot;
              j_d             = j_q + 1'b1;
              state_d         = bld_pkg::S_SHIFT;
            end else begin
              held_d = held_q - 1'b1;
            end
          end
          default: ;
        endcase
      end

      // one entry per cycle: write the word read last cycle one slot toward the front
      bld_pkg::S_SHIFT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = wr_slot_q;
        mem_req_o.wdata = mem_rdata_i;
        if (j_q < held_q) begin
          pos             = j_q[bld_pkg::ADDR_W-1:0];
          mem_req_o.raddr = slot;
          wr_slot_d       = rd_slot_q;
          rd_slot_d       = slot;
          j_d             = j_q + 1'b1;
        end else begin
          held_d  = held_q - 1'b1;
          state_d = bld_pkg::S_DONE;
        end
      end

      bld_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = bld_pkg::S_IDLE;
        end
      end

      default: state_d = bld_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o   = (state_q == bld_pkg::S_IDLE);
  assign res_valid_o  = (state_q == bld_pkg::S_DONE);
  assign res_o.data   = data_q;
  assign res_o.status = status_q;
  assign res_o.count  = held_q;

endmodule
